@@ hdl/dak_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dak_pkg;

	localparam int NUM_KEYS    = 3;
	localparam int COUNT_WIDTH = 16;

	// register file
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = CFG_IDX_W'(1);

	localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RESET = CFG_DATA_W'(300);
	localparam logic [CFG_DATA_W-1:0] REPEAT_RESET     = CFG_DATA_W'(100);

	// stream words, padded to whole bytes
	localparam int S_DATA_W = ((2 * NUM_KEYS + 7) / 8) * 8;
	localparam int M_DATA_W = ((3 * NUM_KEYS + 7) / 8) * 8;

	typedef logic [NUM_KEYS-1:0]    key_vec_t;
	typedef logic [COUNT_WIDTH-1:0] count_t;

endpackage

`default_nettype wire

@@ hdl/debounce_autorepeat_keys_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Dir | Handshake             | Payload
// ----------+-----+-----------------------+-----------------------------------------
// s_*       | in  | s_tvalid / s_tready   | s_tdata: raw_levels, ack_mask
// m_*       | out | m_tvalid / m_tready   | m_tdata: press_events, taken, pending_after
// cfg_*     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data (0 long press, 1 repeat)
//
// One word per clock sustained while m_tready stays high. A word waits in the input register,
// then the per-key debounce/countdown logic updates key state and loads the result register.
// m_tvalid rises when the word moves from the input register into the result register.
// arst_n clears key state, counters (to the long-press reset load) and both valid flags.
// While the result waits on m_tready, one more word is still taken into the input
// register; s_tready drops only when both stages are full. cfg_ready is always high.

module debounce_autorepeat_keys_unit (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// [2:0] raw_levels, [5:3] ack_mask, rest zero
	input  wire  [dak_pkg::S_DATA_W-1:0]          s_tdata,
	input  wire                                   s_tvalid,
	output logic                                  s_tready,
	// [2:0] press_events, [5:3] taken, [8:6] pending_after, rest zero
	output logic [dak_pkg::M_DATA_W-1:0]          m_tdata,
	output logic                                  m_tvalid,
	input  wire                                   m_tready,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire  [dak_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire  [dak_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import dak_pkg::*;

	// config registers
	logic [CFG_DATA_W-1:0] long_press_q;
	logic [CFG_DATA_W-1:0] repeat_q;

	// input stage
	logic     valid_s1;
	key_vec_t raw_s1;
	key_vec_t ack_s1;

	// per-key state; hist holds the two newest samples, [1] newest
	logic [1:0] hist_q [NUM_KEYS];
	key_vec_t   acc_q;
	key_vec_t   held_q;
	key_vec_t   pend_q;
	count_t     cnt_q  [NUM_KEYS];

	// next state
	logic [1:0] hist_d [NUM_KEYS];
	key_vec_t   acc_d;
	key_vec_t   held_d;
	key_vec_t   pend_d;
	count_t     cnt_d  [NUM_KEYS];
	key_vec_t   ev_d;
	key_vec_t   taken_d;
	key_vec_t   left_d;

	logic out_free;
	logic advance;

	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid || m_tready;
	assign advance   = valid_s1 && out_free;
	assign s_tready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q <= LONG_PRESS_RESET;
			repeat_q     <= REPEAT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LONG_PRESS: long_press_q <= cfg_data;
				REG_REPEAT:     repeat_q     <= cfg_data;
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			raw_s1 <= s_tdata[NUM_KEYS-1:0];
			ack_s1 <= s_tdata[2*NUM_KEYS-1:NUM_KEYS];
		end
	end

	// per-key tick; keys are independent
	always_comb begin
		count_t dec;
		logic   lvl;
		logic   stable;
		dec    = '0;
		lvl    = 1'b0;
		stable = 1'b0;
		acc_d  = acc_q;
		held_d = held_q;
		pend_d = pend_q;
		ev_d   = '0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			lvl       = raw_s1[k];
			hist_d[k] = {lvl, hist_q[k][1]};
			cnt_d[k]  = cnt_q[k];
			stable    = (hist_q[k][1] == lvl) && (hist_q[k][0] == lvl);
			dec       = (cnt_q[k] != '0) ? cnt_q[k] - 1'b1 : '0;
			if (stable) begin
				if (acc_q[k] != lvl) begin
					acc_d[k] = lvl;
					if (lvl) begin
						pend_d[k] = 1'b1;
						ev_d[k]   = 1'b1;
						held_d[k] = 1'b1;
						// first press waits the long delay, repeats the short one
						cnt_d[k]  = held_q[k] ? COUNT_WIDTH'(repeat_q)
						                      : COUNT_WIDTH'(long_press_q);
					end
				end else begin
					if (!lvl) begin
						held_d[k] = 1'b0;
					end
					cnt_d[k] = dec;
					// expired countdown drops the level so the next pressed tick repeats
					if (dec == '0) begin
						acc_d[k] = 1'b0;
					end
				end
			end
		end
		// acknowledge sees this tick's events
		taken_d = pend_d & ack_s1;
		left_d  = pend_d & ~ack_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				hist_q[k] <= '0;
				cnt_q[k]  <= COUNT_WIDTH'(LONG_PRESS_RESET);
			end
			acc_q    <= '0;
			held_q   <= '0;
			pend_q   <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (advance) begin
				for (int k = 0; k < NUM_KEYS; k++) begin
					hist_q[k] <= hist_d[k];
					cnt_q[k]  <= cnt_d[k];
				end
				acc_q  <= acc_d;
				held_q <= held_d;
				pend_q <= left_d;
			end
			if (out_free) begin
				m_tvalid <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata <= M_DATA_W'({left_d, taken_d, ev_d});
		end
	end

	// a key accepted as pressed always carries its held mark
	a_acc_held: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_q & ~held_q) == '0)
		else $error("accepted level without held mark");

	// a flag is either handed back or kept, never both
	a_take_xor_keep: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2*NUM_KEYS-1:NUM_KEYS] & m_tdata[3*NUM_KEYS-1:2*NUM_KEYS]) == '0)
		else $error("pending flag both taken and kept");

	// every event shows up as pending or taken in the same word
	a_event_pending: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[NUM_KEYS-1:0] & ~(m_tdata[2*NUM_KEYS-1:NUM_KEYS]
			| m_tdata[3*NUM_KEYS-1:2*NUM_KEYS])) == '0)
		else $error("event lost its pending flag");

	// a stalled input word is not dropped
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1 && $stable(raw_s1) && $stable(ack_s1))
		else $error("input stage lost a word");

	// pending state only moves when a word is processed
	a_pend_still: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(pend_q))
		else $error("pending flags changed without a word");

endmodule

`default_nettype wire
